### sv/humidity_temp_frame_checker_defines.svh
// assertion macros for the humidity and temperature frame checker
`ifndef HUMIDITY_TEMP_FRAME_CHECKER_DEFINES_SVH
`define HUMIDITY_TEMP_FRAME_CHECKER_DEFINES_SVH

`ifndef SYNTHESIS
// checked while out of reset
`define HTFC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("htfc check failed");
// checked on every edge, reset included
`define HTFC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("htfc check failed");
`else
`define HTFC_ASSERT(lbl, clk, rst_n, prop)
`define HTFC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### sv/htfc_pkg.sv
`default_nettype none

package htfc_pkg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } t_in_word;

    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic [13:0]        humidity_centi;
        logic               frame_status;
    } t_out_word;

    localparam logic [7:0] CRC_INIT     = 8'hFF;
    localparam logic [7:0] POLY_RESET   = 8'h31;

    // frame byte positions
    localparam logic [2:0] POS_TEMP_HI  = 3'd0;
    localparam logic [2:0] POS_TEMP_LO  = 3'd1;
    localparam logic [2:0] POS_TEMP_CRC = 3'd2;
    localparam logic [2:0] POS_HUMI_HI  = 3'd3;
    localparam logic [2:0] POS_HUMI_LO  = 3'd4;
    localparam logic [2:0] POS_HUMI_CRC = 3'd5;

    // scaling: value = (scale * raw) >> 16, temperature less the offset
    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [13:0] HUMI_SCALE  = 14'd10000;
    localparam logic [15:0] TEMP_OFFSET = 16'd4500;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_CRC_ERR = 1'b1;

endpackage

`default_nettype wire

### sv/humidity_temp_frame_checker.sv
// Takes a sensor measurement frame one byte per word (temperature high, low,
// CRC, humidity high, low, CRC), checks both CRC-8 words (MSB first, init
// 0xFF, polynomial from the config register, 0x31 after reset) and on the
// sixth byte emits temperature in hundredths of a degree C, humidity in
// hundredths of a percent and a status; on a checksum error both values are
// zero and the status is set. frame_start forces the byte to be the first of
// a new frame and drops any partial frame. One byte is accepted every cycle
// while o_in_stall is low; the CRC step happens on accept, the two
// constant-scale multiplies take one more stage, to the output. A result
// stalled at the output holds one further finished frame before input stalls.
`default_nettype none
`include "humidity_temp_frame_checker_defines.svh"

module humidity_temp_frame_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire htfc_pkg::t_in_word i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output htfc_pkg::t_out_word     o_out_word,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [7:0]         i_cfg_data
);
    import htfc_pkg::*;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    logic [7:0]  r_poly;
    logic [2:0]  r_pos,       n_pos;
    logic [7:0]  r_crc,       n_crc;
    logic [15:0] r_temp_raw,  n_temp_raw;
    logic [15:0] r_humi_raw,  n_humi_raw;
    logic        r_temp_good, n_temp_good;

    logic        r_s1_valid;
    logic        r_s1_good;
    logic [15:0] r_s1_temp;
    logic [15:0] r_s1_humi;

    logic        r_out_valid;
    t_out_word   r_out_word;

    logic        w_in_accept;
    logic        w_out_free;
    logic        w_s1_move;
    logic        w_emit;
    logic        w_emit_good;
    logic [2:0]  w_pos;
    logic [7:0]  w_crc_base;
    logic [7:0]  w_crc_upd;
    logic [30:0] w_t_prod;
    logic [29:0] w_h_prod;
    logic [15:0] w_t_centi;
    t_out_word   w_result;

    assign o_cfg_ready = 1'b1;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_s1_move   = r_s1_valid && w_out_free;
    assign o_in_stall  = r_s1_valid && !w_out_free;
    assign w_in_accept = i_in_valid && !o_in_stall;

    assign w_pos      = i_in_word.frame_start ? POS_TEMP_HI : r_pos;
    assign w_crc_base = i_in_word.frame_start ? CRC_INIT : r_crc;
    assign w_crc_upd  = crc8_byte(w_crc_base, i_in_word.rx_byte, r_poly);

    always_comb begin
        n_pos       = (w_pos >= POS_HUMI_CRC) ? POS_TEMP_HI : w_pos + 3'd1;
        n_crc       = w_crc_upd;
        n_temp_raw  = r_temp_raw;
        n_humi_raw  = r_humi_raw;
        n_temp_good = r_temp_good;
        w_emit      = 1'b0;
        w_emit_good = 1'b0;
        case (w_pos)
            POS_TEMP_HI:  n_temp_raw = {i_in_word.rx_byte, r_temp_raw[7:0]};
            POS_TEMP_LO:  n_temp_raw = {r_temp_raw[15:8], i_in_word.rx_byte};
            POS_TEMP_CRC: begin
                n_temp_good = (w_crc_base == i_in_word.rx_byte);
                n_crc       = CRC_INIT;
            end
            POS_HUMI_HI:  n_humi_raw = {i_in_word.rx_byte, r_humi_raw[7:0]};
            POS_HUMI_LO:  n_humi_raw = {r_humi_raw[15:8], i_in_word.rx_byte};
            default: begin
                w_emit      = 1'b1;
                w_emit_good = r_temp_good && (w_crc_base == i_in_word.rx_byte);
                n_crc       = CRC_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly      <= POLY_RESET;
            r_pos       <= POS_TEMP_HI;
            r_crc       <= CRC_INIT;
            r_temp_raw  <= '0;
            r_humi_raw  <= '0;
            r_temp_good <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_poly <= i_cfg_data;
            end
            if (w_in_accept) begin
                r_pos       <= n_pos;
                r_crc       <= n_crc;
                r_temp_raw  <= n_temp_raw;
                r_humi_raw  <= n_humi_raw;
                r_temp_good <= n_temp_good;
            end
        end
    end

    // finished frame waits here for the scaling stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_accept && w_emit) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept && w_emit) begin
            r_s1_good <= w_emit_good;
            r_s1_temp <= r_temp_raw;
            r_s1_humi <= r_humi_raw;
        end
    end

    assign w_t_prod  = {16'd0, TEMP_SCALE} * {15'd0, r_s1_temp};
    assign w_h_prod  = {16'd0, HUMI_SCALE} * {14'd0, r_s1_humi};
    assign w_t_centi = {1'b0, w_t_prod[30:16]} - TEMP_OFFSET;

    always_comb begin
        if (r_s1_good) begin
            w_result.temperature_centi = $signed(w_t_centi[14:0]);
            w_result.humidity_centi    = w_h_prod[29:16];
            w_result.frame_status      = STATUS_OK;
        end else begin
            w_result.temperature_centi = '0;
            w_result.humidity_centi    = '0;
            w_result.frame_status      = STATUS_CRC_ERR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_out_word <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `HTFC_ASSERT(a_err_zero, i_clk, i_rst_n, (o_out_valid && o_out_word.frame_status) |-> (o_out_word.temperature_centi == '0 && o_out_word.humidity_centi == '0))
    `HTFC_ASSERT(a_pos_range, i_clk, i_rst_n, r_pos <= POS_HUMI_CRC)
    `HTFC_ASSERT(a_out_from_s1, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(r_s1_valid))
    `HTFC_ASSERT(a_s1_kept, i_clk, i_rst_n, (r_s1_valid && !w_out_free) |=> r_s1_valid)

endmodule

`default_nettype wire

### bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import htfc_pkg::*;

    typedef enum logic [1:0] {BYTE_LIT, BYTE_CRC_OK, BYTE_CRC_BAD} t_byte_src;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        t_byte_src  src;
        logic       typed;
        t_out_word  want;
    } t_stim_row;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    t_in_word   i_in_word   = '0;
    logic       i_out_stall = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [7:0] i_cfg_data  = '0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_word  o_out_word;
    logic       o_cfg_ready;

    // frame decoder mirror
    logic [7:0]  poly_acc = POLY_RESET;
    logic [2:0]  pos_acc  = POS_TEMP_HI;
    logic [7:0]  crc_acc  = CRC_INIT;
    logic [15:0] temp_acc = '0;
    logic [15:0] humi_acc = '0;
    logic        temp_ok  = 1'b0;

    t_out_word frame_results_due[$];
    t_stim_row dir_rows[$];

    int fault_count   = 0;
    int bytes_sent    = 0;
    int results_seen  = 0;
    int crc_err_seen  = 0;
    int poly_writes   = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    logic [15:0] frame_temp;
    logic [15:0] frame_humi;

    humidity_temp_frame_checker u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ poly_acc;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    task automatic frame_update(input t_in_word w, output bit got, output t_out_word res);
        logic [2:0]  p;
        logic        good;
        int unsigned tprod;
        int unsigned hprod;
        int          tval;
        got = 1'b0;
        res = '0;
        if (w.frame_start) begin
            pos_acc = POS_TEMP_HI;
            crc_acc = CRC_INIT;
        end
        p = pos_acc;
        case (p)
            POS_TEMP_HI: begin
                temp_acc[15:8] = w.rx_byte;
                crc_acc = crc8_step(crc_acc, w.rx_byte);
            end
            POS_TEMP_LO: begin
                temp_acc[7:0] = w.rx_byte;
                crc_acc = crc8_step(crc_acc, w.rx_byte);
            end
            POS_TEMP_CRC: begin
                temp_ok = (crc_acc == w.rx_byte);
                crc_acc = CRC_INIT;
            end
            POS_HUMI_HI: begin
                humi_acc[15:8] = w.rx_byte;
                crc_acc = crc8_step(crc_acc, w.rx_byte);
            end
            POS_HUMI_LO: begin
                humi_acc[7:0] = w.rx_byte;
                crc_acc = crc8_step(crc_acc, w.rx_byte);
            end
            default: begin
                good = temp_ok && (crc_acc == w.rx_byte);
                if (good) begin
                    tprod = 32'd17500 * {16'd0, temp_acc};
                    hprod = 32'd10000 * {16'd0, humi_acc};
                    tval  = int'(tprod >> 16) - 4500;
                    res.temperature_centi = 15'(tval);
                    res.humidity_centi    = 14'(hprod >> 16);
                end
                res.frame_status = good ? STATUS_OK : STATUS_CRC_ERR;
                crc_acc = CRC_INIT;
                got = 1'b1;
            end
        endcase
        pos_acc = (p >= POS_HUMI_CRC) ? POS_TEMP_HI : p + 3'd1;
    endtask

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic push_byte(input logic [7:0] b, input logic s, input logic typed,
                             input t_out_word want);
        t_in_word  w;
        bit        got;
        t_out_word pred;
        w.rx_byte     = b;
        w.frame_start = s;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        frame_update(w, got, pred);
        if (typed) begin
            frame_results_due.push_back(want);
        end else if (got) begin
            frame_results_due.push_back(pred);
        end
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic choose_frame_words();
        int r;
        r = $urandom_range(0, 15);
        frame_temp = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
        r = $urandom_range(0, 15);
        frame_humi = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
    endtask

    // bad_mask bit 0 spoils the temperature checksum, bit 1 the humidity one
    task automatic send_frame_part(input int lo, input int hi, input logic start_first,
                                   input logic [1:0] bad_mask);
        logic [7:0] b;
        for (int p = lo; p <= hi; p++) begin
            case (p[2:0])
                POS_TEMP_HI:  b = frame_temp[15:8];
                POS_TEMP_LO:  b = frame_temp[7:0];
                POS_TEMP_CRC: b = bad_mask[0] ? crc_acc ^ 8'($urandom_range(1, 255)) : crc_acc;
                POS_HUMI_HI:  b = frame_humi[15:8];
                POS_HUMI_LO:  b = frame_humi[7:0];
                default:      b = bad_mask[1] ? crc_acc ^ 8'($urandom_range(1, 255)) : crc_acc;
            endcase
            push_byte(b, (p == lo) ? start_first : 1'b0, 1'b0, '0);
        end
    endtask

    // let the output side drain, then give the pipeline time to go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (frame_results_due.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_poly(input logic [7:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        poly_acc = v;
        poly_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_stim_row row_in(input logic [7:0] d, input logic s, input t_byte_src src);
        t_stim_row r;
        r       = '0;
        r.data  = d;
        r.start = s;
        r.src   = src;
        return r;
    endfunction

    function automatic t_stim_row row_out(input logic [7:0] d, input logic s, input t_byte_src src,
                                          input int t, input int h, input logic st);
        t_stim_row r;
        r = row_in(d, s, src);
        r.typed                  = 1'b1;
        r.want.temperature_centi = 15'(t);
        r.want.humidity_centi    = 14'(h);
        r.want.frame_status      = st;
        return r;
    endfunction

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin : check_out
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (frame_results_due.size() == 0) begin
                $error("unexpected result word: temperature_centi %0d", $signed(o_out_word.temperature_centi));
                fault_count++;
            end else begin
                want = frame_results_due.pop_front();
                if (want.frame_status == STATUS_CRC_ERR) crc_err_seen++;
                if (o_out_word.temperature_centi !== want.temperature_centi) begin
                    $error("temperature_centi: expected %0d, actual %0d",
                           $signed(want.temperature_centi), $signed(o_out_word.temperature_centi));
                    fault_count++;
                end
                if (o_out_word.humidity_centi !== want.humidity_centi) begin
                    $error("humidity_centi: expected %0d, actual %0d",
                           want.humidity_centi, o_out_word.humidity_centi);
                    fault_count++;
                end
                if (o_out_word.frame_status !== want.frame_status) begin
                    $error("frame_status: expected %0d, actual %0d",
                           want.frame_status, o_out_word.frame_status);
                    fault_count++;
                end
            end
        end
    end

    initial begin
        logic [7:0] b;
        logic [7:0] phase_poly[5];
        int         split;
        int         phase_start;
        int         k;
        logic       st;

        // known sensor vector: 0xBEEF checks to 0x92 with the reset polynomial
        dir_rows.push_back(row_in(8'hBE, 1'b1, BYTE_LIT));
        dir_rows.push_back(row_in(8'hEF, 1'b0, BYTE_LIT));
        dir_rows.push_back(row_in(8'h92, 1'b0, BYTE_LIT));
        dir_rows.push_back(row_in(8'hBE, 1'b0, BYTE_LIT));
        dir_rows.push_back(row_in(8'hEF, 1'b0, BYTE_LIT));
        dir_rows.push_back(row_in(8'h92, 1'b0, BYTE_LIT));
        // full scale temperature, zero humidity
        dir_rows.push_back(row_in(8'hFF, 1'b1, BYTE_LIT));
        dir_rows.push_back(row_in(8'hFF, 1'b0, BYTE_LIT));
        dir_rows.push_back(row_in(8'h00, 1'b0, BYTE_CRC_OK));
        dir_rows.push_back(row_in(8'h00, 1'b0, BYTE_LIT));
        dir_rows.push_back(row_in(8'h00, 1'b0, BYTE_LIT));
        dir_rows.push_back(row_out(8'h00, 1'b0, BYTE_CRC_OK, 12999, 0, STATUS_OK));
        // partial frame dropped by the next start flag
        dir_rows.push_back(row_in(8'hA5, 1'b1, BYTE_LIT));
        dir_rows.push_back(row_in(8'h5A, 1'b0, BYTE_LIT));
        // humidity checksum wrong
        dir_rows.push_back(row_in(8'h12, 1'b1, BYTE_LIT));
        dir_rows.push_back(row_in(8'h34, 1'b0, BYTE_LIT));
        dir_rows.push_back(row_in(8'h00, 1'b0, BYTE_CRC_OK));
        dir_rows.push_back(row_in(8'h56, 1'b0, BYTE_LIT));
        dir_rows.push_back(row_in(8'h78, 1'b0, BYTE_LIT));
        dir_rows.push_back(row_out(8'h00, 1'b0, BYTE_CRC_BAD, 0, 0, STATUS_CRC_ERR));
        // temperature checksum wrong, frame begun by wrap with no start flag
        dir_rows.push_back(row_in(8'h00, 1'b0, BYTE_LIT));
        dir_rows.push_back(row_in(8'h00, 1'b0, BYTE_LIT));
        dir_rows.push_back(row_in(8'h00, 1'b0, BYTE_CRC_BAD));
        dir_rows.push_back(row_in(8'hFF, 1'b0, BYTE_LIT));
        dir_rows.push_back(row_in(8'hFF, 1'b0, BYTE_LIT));
        dir_rows.push_back(row_out(8'h00, 1'b0, BYTE_CRC_OK, 0, 0, STATUS_CRC_ERR));

        phase_poly[0] = 8'h00;
        phase_poly[1] = 8'hFF;
        phase_poly[2] = 8'($urandom_range(0, 255));
        phase_poly[3] = POLY_RESET;
        phase_poly[4] = 8'($urandom_range(0, 255));

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i]) begin
            b = dir_rows[i].data;
            if (dir_rows[i].src == BYTE_CRC_OK) b = crc_acc;
            if (dir_rows[i].src == BYTE_CRC_BAD) b = crc_acc ^ 8'h5A;
            push_byte(b, dir_rows[i].start, dir_rows[i].typed, dir_rows[i].want);
        end

        split = 0;
        for (int ph = 0; ph < 5; ph++) begin
            settle();
            write_poly(phase_poly[ph]);
            case ((ph + 1) % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            // finish the frame left open across the polynomial change
            if (ph > 0) send_frame_part(split + 1, 5, 1'b0, 2'b00);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < 100) begin
                k = $urandom_range(0, 19);
                choose_frame_words();
                st = (pos_acc == POS_TEMP_HI) ? 1'($urandom_range(0, 1)) : 1'b1;
                if (k < 14) begin
                    send_frame_part(0, 5, st, 2'b00);
                end else if (k < 16) begin
                    send_frame_part(0, 5, st, 2'($urandom_range(1, 3)));
                end else if (k < 18) begin
                    send_frame_part(0, $urandom_range(0, 4), 1'b1, 2'b00);
                end else begin
                    repeat ($urandom_range(1, 4))
                        push_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0), 1'b0, '0);
                end
            end
            choose_frame_words();
            split = $urandom_range(0, 4);
            send_frame_part(0, split, 1'b1, 2'b00);
        end

        settle();
        repeat (4) @(negedge i_clk);
        $display("covered %0d bytes and %0d frame results, %0d of them checksum errors",
                 bytes_sent, results_seen, crc_err_seen);
        $display("%0d polynomial writes, four pacing modes, frames split across writes",
                 poly_writes);
        if (fault_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
